// ===== rtl/core/hbe_pkg.sv =====
// Shared types, constants and codes for the histogram binning engine.
`default_nettype none

package hbe_pkg;

   // Store geometry
   localparam int MAX_BINS = 256;
   localparam int BIN_W    = $clog2(MAX_BINS);
   localparam int CNT_W    = 32;
   localparam int LOG_W    = 22;

   // Request actions
   localparam logic [1:0] ACT_ADD   = 2'd0;
   localparam logic [1:0] ACT_READ  = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;

   // Back-end operations
   localparam logic [1:0] OP_NONE  = 2'd0;
   localparam logic [1:0] OP_ADD   = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;
   localparam logic [1:0] OP_CLEAR = 2'd3;

   // Register indexes
   localparam logic [1:0] CSR_RANGE_MIN = 2'd0;
   localparam logic [1:0] CSR_RANGE_MAX = 2'd1;
   localparam logic [1:0] CSR_BIN_COUNT = 2'd2;
   localparam logic [1:0] CSR_LOG_SCALE = 2'd3;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] sample_value;
      logic        sample_ok;
      logic [7:0]  bin_select;
   } req_type;

   typedef struct packed {
      logic [7:0]       bin_number;
      logic             was_counted;
      logic [CNT_W-1:0] bin_value;
   } rsp_type;

   typedef struct packed {
      logic [31:0] range_min;
      logic [31:0] range_max;
      logic [8:0]  bin_count;
      logic        log_scale;
   } cfg_type;

   typedef struct packed {
      logic [1:0]       op;
      logic [BIN_W-1:0] idx;
      logic [7:0]       bin_number;
   } cmd_type;

endpackage

`default_nettype wire

// ===== rtl/core/histogram_binning_engine_core.sv =====
// Top level of the histogram binning engine: registers, front end, queue, back end.
//
//   channel   direction  signals
//   req       in         req_valid, req_ready, req_data (req_type)
//   rsp       out        rsp_valid, rsp_ready, rsp_data (rsp_type)
//   csr       in         csr_write, csr_index, csr_data (write only)
//
// On its way from request to result, a read or clear goes straight to the back
// end; a linear sample also passes the range check, the multiply and the 9-step
// restoring divider; a log sample first makes three passes through the shared log2
// unit (5 normalise steps and 16 squaring steps each), then takes the linear path.
// Reset is synchronous and marks every bin empty at once; no clearing pass.
// A stalled response holds in the output register while the front end works
// on the next request; the two-entry queue absorbs the difference.
`default_nettype none

module histogram_binning_engine_core import hbe_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_data
);

   cfg_type cfg_ff, cfg_in;
   logic    fq_valid, fq_ready, bq_valid, bq_ready;
   cmd_type fq_cmd, bq_cmd;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_RANGE_MIN: cfg_in.range_min = csr_data;
            CSR_RANGE_MAX: cfg_in.range_max = csr_data;
            CSR_BIN_COUNT: cfg_in.bin_count = csr_data[8:0];
            CSR_LOG_SCALE: cfg_in.log_scale = csr_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.range_min <= 32'd0;
         cfg_ff.range_max <= 32'd65536;
         cfg_ff.bin_count <= 9'd256;
         cfg_ff.log_scale <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   hbe_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cfg       (cfg_ff),
      .cmd_valid (fq_valid),
      .cmd_ready (fq_ready),
      .cmd       (fq_cmd)
   );

   hbe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_data  (fq_cmd),
      .pop_valid  (bq_valid),
      .pop_ready  (bq_ready),
      .pop_data   (bq_cmd)
   );

   hbe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (bq_valid),
      .cmd_ready (bq_ready),
      .cmd       (bq_cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== rtl/core/hbe_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module hbe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/hbe_queue.sv =====
// Two-entry command queue between the binning front end and the counter back end.
`default_nettype none

module hbe_queue import hbe_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push_valid,
   output logic         push_ready,
   input  wire cmd_type push_data,
   output logic         pop_valid,
   input  wire logic    pop_ready,
   output cmd_type      pop_data
);

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // advance pointers and fill level
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the pushed entry
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/hbe_front.sv =====
// Front end: accepts requests, computes log2 and the bin index, issues commands.
`default_nettype none

module hbe_front import hbe_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   input  wire cfg_type cfg,
   output logic         cmd_valid,
   input  wire logic    cmd_ready,
   output cmd_type      cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_NORM  = 3'd1;
   localparam logic [2:0] ST_SQR   = 3'd2;
   localparam logic [2:0] ST_CHECK = 3'd3;
   localparam logic [2:0] ST_MUL   = 3'd4;
   localparam logic [2:0] ST_DIV   = 3'd5;
   localparam logic [2:0] ST_PUSH  = 3'd6;

   logic [2:0]              state_ff, state_in;
   logic [31:0]             x_ff, x_in;
   logic [1:0]              which_ff, which_in;
   logic [3:0]              stp_ff, stp_in;
   logic [31:0]             m_ff, m_in;
   logic [4:0]              p_ff, p_in;
   logic [15:0]             frac_ff, frac_in;
   logic signed [LOG_W-1:0] lx_ff, lx_in, lmin_ff, lmin_in, lmax_ff, lmax_in;
   logic [31:0]             num_ff, num_in, den_ff, den_in;
   logic [31:0]             rem_ff, rem_in;
   logic [8:0]              quo_ff, quo_in;
   cmd_type                 cmd_ff, cmd_in;

   logic [8:0]              n_eff;
   logic [4:0]              sh;
   logic                    top_zero;
   logic [63:0]             sq;
   logic [32:0]             sq_t;
   logic [31:0]             m_sq;
   logic [15:0]             frac_nx;
   logic signed [LOG_W-1:0] log_val;
   logic [5:0]              log_int;
   logic signed [LOG_W:0]   dx, dmax;
   logic                    chk_skip;
   logic [31:0]             chk_num, chk_den;
   logic [40:0]             prod;
   logic [32:0]             div_t, div_d;
   logic                    div_ge;
   logic [8:0]              quo_nx;
   logic                    early_skip;

   assign req_ready = (state_ff == ST_IDLE);
   assign cmd_valid = (state_ff == ST_PUSH);
   assign cmd       = cmd_ff;

   // bins in use, limited to the store depth
   assign n_eff = (32'(cfg.bin_count) > MAX_BINS) ? 9'(MAX_BINS) : cfg.bin_count;

   // normalise step: halve the shift each cycle, 16 down to 1
   assign sh       = 5'(5'd16 >> stp_ff[2:0]);
   assign top_zero = ((m_ff >> (6'd32 - 6'(sh))) == 32'd0);

   // squaring step of the mantissa
   assign sq      = 64'(m_ff) * 64'(m_ff);
   assign sq_t    = 33'(sq >> 31);
   assign m_sq    = sq_t[32] ? sq_t[32:1] : sq_t[31:0];
   assign frac_nx = {frac_ff[14:0], sq_t[32]};
   assign log_int = 6'(p_ff) - 6'd16;
   assign log_val = $signed({log_int, frac_nx});

   // range checks and bin numerator and denominator
   always_comb begin
      dx       = $signed({lx_ff[LOG_W-1], lx_ff}) - $signed({lmin_ff[LOG_W-1], lmin_ff});
      dmax     = $signed({lmax_ff[LOG_W-1], lmax_ff}) - $signed({lmin_ff[LOG_W-1], lmin_ff});
      chk_skip = 1'b0;
      if (cfg.log_scale) begin
         chk_num = 32'($unsigned(dx));
         chk_den = 32'($unsigned(dmax));
         if (dx < 0 || dmax <= 0) begin
            chk_skip = 1'b1;
         end
      end else begin
         chk_num = x_ff - cfg.range_min;
         chk_den = cfg.range_max - cfg.range_min;
         if (x_ff < cfg.range_min) begin
            chk_skip = 1'b1;
         end
      end
      if (chk_num >= chk_den) begin
         chk_skip = 1'b1;
      end
   end

   // scaled numerator and one restoring division step
   assign prod   = 41'(num_ff) * 41'(n_eff);
   assign div_t  = {rem_ff, quo_ff[8]};
   assign div_d  = div_t - {1'b0, den_ff};
   assign div_ge = (div_t >= {1'b0, den_ff});
   assign quo_nx = {quo_ff[7:0], div_ge};

   assign early_skip = !req_data.sample_ok || (n_eff == 9'd0)
                    || (cfg.range_max <= cfg.range_min)
                    || (cfg.log_scale && ((cfg.range_min == 32'd0)
                                          || (req_data.sample_value == 32'd0)));

   // sequence one request
   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      which_in = which_ff;
      stp_in   = stp_ff;
      m_in     = m_ff;
      p_in     = p_ff;
      frac_in  = frac_ff;
      lx_in    = lx_ff;
      lmin_in  = lmin_ff;
      lmax_in  = lmax_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      cmd_in   = cmd_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               x_in              = req_data.sample_value;
               cmd_in.op         = OP_NONE;
               cmd_in.idx        = BIN_W'(req_data.bin_select);
               cmd_in.bin_number = 8'd0;
               state_in          = ST_PUSH;
               case (req_data.action)
                  ACT_READ, ACT_CLEAR: begin
                     cmd_in.bin_number = req_data.bin_select;
                     if (32'(req_data.bin_select) < MAX_BINS) begin
                        cmd_in.op = (req_data.action == ACT_READ) ? OP_READ : OP_CLEAR;
                     end
                  end
                  ACT_ADD: begin
                     if (!early_skip) begin
                        if (cfg.log_scale) begin
                           m_in     = req_data.sample_value;
                           p_in     = 5'd31;
                           stp_in   = 4'd0;
                           which_in = 2'd0;
                           state_in = ST_NORM;
                        end else begin
                           state_in = ST_CHECK;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_NORM: begin
            if (top_zero) begin
               m_in = m_ff << sh;
               p_in = p_ff - sh;
            end
            stp_in = stp_ff + 4'd1;
            if (stp_ff == 4'd4) begin
               stp_in   = 4'd0;
               frac_in  = 16'd0;
               state_in = ST_SQR;
            end
         end
         ST_SQR: begin
            m_in    = m_sq;
            frac_in = frac_nx;
            stp_in  = stp_ff + 4'd1;
            if (stp_ff == 4'd15) begin
               stp_in = 4'd0;
               p_in   = 5'd31;
               case (which_ff)
                  2'd0: begin
                     lx_in    = log_val;
                     m_in     = cfg.range_min;
                     which_in = 2'd1;
                     state_in = ST_NORM;
                  end
                  2'd1: begin
                     lmin_in  = log_val;
                     m_in     = cfg.range_max;
                     which_in = 2'd2;
                     state_in = ST_NORM;
                  end
                  default: begin
                     lmax_in  = log_val;
                     state_in = ST_CHECK;
                  end
               endcase
            end
         end
         ST_CHECK: begin
            num_in   = chk_num;
            den_in   = chk_den;
            state_in = chk_skip ? ST_PUSH : ST_MUL;
         end
         ST_MUL: begin
            rem_in   = prod[40:9];
            quo_in   = prod[8:0];
            stp_in   = 4'd0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in = div_ge ? div_d[31:0] : div_t[31:0];
            quo_in = quo_nx;
            stp_in = stp_ff + 4'd1;
            if (stp_ff == 4'd8) begin
               cmd_in.op         = OP_ADD;
               cmd_in.idx        = BIN_W'(quo_nx);
               cmd_in.bin_number = quo_nx[7:0];
               state_in          = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (cmd_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      which_ff <= which_in;
      stp_ff   <= stp_in;
      m_ff     <= m_in;
      p_ff     <= p_in;
      frac_ff  <= frac_in;
      lx_ff    <= lx_in;
      lmin_ff  <= lmin_in;
      lmax_ff  <= lmax_in;
      num_ff   <= num_in;
      den_ff   <= den_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      cmd_ff   <= cmd_in;
   end

endmodule

`default_nettype wire

// ===== rtl/core/hbe_back.sv =====
// Back end: counter read-modify-write on the bin store and the response register.
`default_nettype none

module hbe_back import hbe_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    cmd_valid,
   output logic         cmd_ready,
   input  wire cmd_type cmd,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   localparam logic BK_IDLE = 1'b0;
   localparam logic BK_WAIT = 1'b1;

   logic                  state_ff, state_in;
   cmd_type               pend_ff, pend_in;
   logic [MAX_BINS-1:0]   valid_ff, valid_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  out_free;
   logic                  ram_we, ram_re;
   logic [CNT_W-1:0]      ram_wdata, ram_rdata, cur, inc;

   hbe_ram #(
      .WIDTH (CNT_W),
      .DEPTH (MAX_BINS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (pend_ff.idx),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (cmd.idx),
      .rd_data (ram_rdata)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // never-written bins read as zero; saturate the increment
   assign cur       = valid_ff[pend_ff.idx] ? ram_rdata : '0;
   assign inc       = (cur == '1) ? cur : cur + 1'b1;
   assign ram_wdata = inc;

   always_comb begin
      state_in     = state_ff;
      pend_in      = pend_ff;
      valid_in     = valid_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd_ready    = 1'b0;
      ram_re       = 1'b0;
      ram_we       = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (cmd_valid) begin
               if (cmd.op == OP_NONE) begin
                  // drop straight to the response register
                  if (out_free) begin
                     cmd_ready          = 1'b1;
                     rsp_in.bin_number  = cmd.bin_number;
                     rsp_in.was_counted = 1'b0;
                     rsp_in.bin_value   = '0;
                     rsp_valid_in       = 1'b1;
                  end
               end else begin
                  cmd_ready = 1'b1;
                  ram_re    = 1'b1;
                  pend_in   = cmd;
                  state_in  = BK_WAIT;
               end
            end
         end
         BK_WAIT: begin
            if (out_free) begin
               rsp_in.bin_number  = pend_ff.bin_number;
               rsp_in.was_counted = (pend_ff.op == OP_ADD);
               rsp_in.bin_value   = cur;
               rsp_valid_in       = 1'b1;
               state_in           = BK_IDLE;
               if (pend_ff.op == OP_ADD) begin
                  ram_we                = 1'b1;
                  valid_in[pend_ff.idx] = 1'b1;
                  rsp_in.bin_value      = inc;
               end else if (pend_ff.op == OP_CLEAR) begin
                  valid_in[pend_ff.idx] = 1'b0;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold command and response payload
   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

endmodule

`default_nettype wire
